// ===== hdl/cdf_pkg.sv =====
// Package for the critically damped follower: shared types, codes and
// saturation helpers. Used by cdf_alu and critically_damped_follower.
package cdf_pkg;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] lo;
    logic [63:0] hi;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_OM,
    S_X,
    S_X2,
    S_X3,
    S_T1,
    S_T2,
    S_DEC,
    S_MC,
    S_SQ,
    S_MC2,
    S_SQRT,
    S_SCM,
    S_SCD,
    S_A,
    S_B,
    S_C,
    S_D,
    S_E,
    S_DOT,
    S_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic signed [31:0] satsym(input logic signed [63:0] v);
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      satsym = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_7FFF_FFFF) begin
      satsym = -32'sh7FFF_FFFF;
    end else begin
      satsym = v[31:0];
    end
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    abs32 = v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

// ===== hdl/critically_damped_follower.sv =====
// Top level of the critically damped follower: sequencer, registers and
// output stage around the shared unit cdf_alu. Depends on cdf_pkg.
//
//   channel  direction  handshake              payload
//   in_      slave      in_tvalid/in_tready    in_tdata  (224 bits)
//   out_     master     out_tvalid/out_tready  out_tdata (192 bits)
//   cfg_     write      cfg_we                 cfg_index, cfg_wdata
//
// An item needs 30 operations on the shared unit; with the offset limited
// it needs six more and the root. The single 66-bit adder iterates one bit
// per cycle. Reset clears the velocity and restores the registers. A result
// waits in the output register while the next item is accepted; the item
// completes once that register is free.
module critically_damped_follower #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // cur_x, cur_y, cur_z, target_x, target_y, target_z, delta_time, pad
  input  logic [223:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // out_x, out_y, out_z, vel_x, vel_y, vel_z
  output logic [191:0] out_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [30:0]  cfg_wdata
);

  localparam logic [63:0] ONE_Q   = 64'(1) << FRAC_BITS;
  localparam logic [63:0] DEN_CAP = (64'(1) << (2 * FRAC_BITS)) + 64'(1);
  localparam logic [63:0] OM_NUM  = 64'(2) << (2 * FRAC_BITS);
  localparam logic [63:0] DEC_NUM = 64'(1) << (2 * FRAC_BITS);
  localparam logic [63:0] K_048   = (64'(48) * ONE_Q + 64'(50)) / 64'(100);
  localparam logic [63:0] K_0235  = (64'(235) * ONE_Q + 64'(500)) / 64'(1000);
  localparam logic [63:0] ST_RAW  = (ONE_Q + 64'(5000)) / 64'(10000);
  localparam logic [30:0] ST_MIN  = (ST_RAW < 64'(1)) ? 31'(1) : 31'(ST_RAW);
  localparam logic [63:0] S31_MAX = 64'h0000_0000_7FFF_FFFF;

  function automatic logic [63:0] capf(input logic [127:0] p);
    logic [63:0] s;
    s = p[63:0] >> FRAC_BITS;
    if (p[127:64] != '0) begin
      capf = DEN_CAP;
    end else if (s > DEN_CAP) begin
      capf = DEN_CAP;
    end else begin
      capf = s;
    end
  endfunction

  cdf_pkg::state_t   state_r, state_nxt;
  cdf_pkg::alu_req_t alu_req;
  cdf_pkg::alu_rsp_t alu_rsp;

  logic [30:0] st_r, st_nxt, ms_r, ms_nxt, st_eff;
  logic [30:0] dt_r, dt_nxt, om_r, om_nxt, mc_r, mc_nxt;
  logic [63:0] x_r, x_nxt, x2_r, x2_nxt, x3_r, x3_nxt, t1_r, t1_nxt;
  logic [63:0] den_r, den_nxt, sq_r, sq_nxt, pp_r, pp_nxt;
  logic [31:0] dec_r, dec_nxt, len_r, len_nxt;
  logic signed [31:0] cur_r [3], cur_nxt [3];
  logic signed [31:0] tgt_r [3], tgt_nxt [3];
  logic signed [31:0] chg_r [3], chg_nxt [3];
  logic signed [31:0] vel_r [3], vel_nxt [3];
  logic signed [31:0] nv_r [3], nv_nxt [3];
  logic signed [31:0] o_r [3], o_nxt [3];
  logic signed [31:0] s_r, s_nxt, tmp_r, tmp_nxt;
  logic signed [65:0] dot_r, dot_nxt;
  logic [1:0]  ax_r, ax_nxt;
  logic        wait_r, wait_nxt, sign_r, sign_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [191:0] out_data_r, out_data_nxt;

  logic        fin, over;
  logic [127:0] prod;
  logic [63:0] m, t2, xm, den_sum;
  logic signed [63:0] m_s, q_s;
  logic signed [65:0] pd;
  logic signed [31:0] w, va, vb;

  cdf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  assign st_eff = (st_r < ST_MIN) ? ST_MIN : st_r;

  always_comb begin
    state_nxt = state_r;
    st_nxt = st_r;   ms_nxt = ms_r;   dt_nxt = dt_r;   om_nxt = om_r;
    mc_nxt = mc_r;   x_nxt = x_r;     x2_nxt = x2_r;   x3_nxt = x3_r;
    t1_nxt = t1_r;   den_nxt = den_r; sq_nxt = sq_r;   pp_nxt = pp_r;
    dec_nxt = dec_r; len_nxt = len_r; s_nxt = s_r;     tmp_nxt = tmp_r;
    dot_nxt = dot_r; ax_nxt = ax_r;   sign_nxt = sign_r;
    cur_nxt = cur_r; tgt_nxt = tgt_r; chg_nxt = chg_r; vel_nxt = vel_r;
    nv_nxt = nv_r;   o_nxt = o_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wait_nxt = wait_r;
    alu_req  = '0;
    fin  = wait_r && alu_rsp.done;
    prod = {alu_rsp.hi, alu_rsp.lo};
    m    = alu_rsp.lo >> FRAC_BITS;
    m_s  = sign_r ? -$signed(m) : $signed(m);
    q_s  = sign_r ? -$signed(alu_rsp.lo) : $signed(alu_rsp.lo);
    pd   = $signed({2'b00, alu_rsp.lo});
    t2   = capf(prod);
    xm   = (x_r > DEN_CAP) ? DEN_CAP : x_r;
    den_sum = ONE_Q + xm + t1_r + t2;
    w    = cdf_pkg::sat32(64'(chg_r[ax_r]) + 64'(tmp_r));
    va   = cdf_pkg::satsym(64'(tgt_r[ax_r]) - 64'(cur_r[ax_r]));
    vb   = cdf_pkg::satsym(64'(o_r[ax_r]) - 64'(tgt_r[ax_r]));
    over = dot_r > 66'sd0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        st_nxt = cfg_wdata;
      end else begin
        ms_nxt = cfg_wdata;
      end
    end

    case (state_r)
      cdf_pkg::S_IDLE: begin
        if (in_tvalid) begin
          for (int i = 0; i < 3; i++) begin
            cur_nxt[i] = $signed(in_tdata[32*i +: 32]);
            tgt_nxt[i] = $signed(in_tdata[96 + 32*i +: 32]);
            chg_nxt[i] = cdf_pkg::sat32(64'($signed(in_tdata[32*i +: 32]))
                         - 64'($signed(in_tdata[96 + 32*i +: 32])));
          end
          dt_nxt    = in_tdata[222:192];
          state_nxt = cdf_pkg::S_OM;
        end
      end
      cdf_pkg::S_OM: begin
        alu_req.op = cdf_pkg::ALU_DIV;
        alu_req.a  = OM_NUM;
        alu_req.b  = 64'(st_eff);
        if (fin) begin
          om_nxt    = (alu_rsp.lo > S31_MAX) ? 31'h7FFF_FFFF : alu_rsp.lo[30:0];
          state_nxt = cdf_pkg::S_X;
        end
      end
      cdf_pkg::S_X: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(om_r);
        alu_req.b  = 64'(dt_r);
        if (fin) begin
          x_nxt     = m;
          state_nxt = cdf_pkg::S_X2;
        end
      end
      cdf_pkg::S_X2: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = x_r;
        alu_req.b  = x_r;
        if (fin) begin
          x2_nxt    = t2;
          state_nxt = cdf_pkg::S_X3;
        end
      end
      cdf_pkg::S_X3: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = x2_r;
        alu_req.b  = x_r;
        if (fin) begin
          x3_nxt    = t2;
          state_nxt = cdf_pkg::S_T1;
        end
      end
      cdf_pkg::S_T1: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = K_048;
        alu_req.b  = x2_r;
        if (fin) begin
          t1_nxt    = t2;
          state_nxt = cdf_pkg::S_T2;
        end
      end
      cdf_pkg::S_T2: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = K_0235;
        alu_req.b  = x3_r;
        if (fin) begin
          den_nxt   = (den_sum > DEN_CAP) ? DEN_CAP : den_sum;
          state_nxt = cdf_pkg::S_DEC;
        end
      end
      cdf_pkg::S_DEC: begin
        alu_req.op = cdf_pkg::ALU_DIV;
        alu_req.a  = DEC_NUM;
        alu_req.b  = den_r;
        if (fin) begin
          dec_nxt   = alu_rsp.lo[31:0];
          state_nxt = cdf_pkg::S_MC;
        end
      end
      cdf_pkg::S_MC: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(ms_r);
        alu_req.b  = 64'(st_eff);
        if (fin) begin
          mc_nxt    = (m > S31_MAX) ? 31'h7FFF_FFFF : m[30:0];
          sq_nxt    = '0;
          ax_nxt    = 2'd0;
          state_nxt = cdf_pkg::S_SQ;
        end
      end
      cdf_pkg::S_SQ: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(cdf_pkg::abs32(chg_r[ax_r]));
        alu_req.b  = 64'(cdf_pkg::abs32(chg_r[ax_r]));
        if (fin) begin
          sq_nxt = sq_r + alu_rsp.lo;
          if (ax_r == 2'd2) begin
            state_nxt = cdf_pkg::S_MC2;
          end else begin
            ax_nxt = ax_r + 2'd1;
          end
        end
      end
      cdf_pkg::S_MC2: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(mc_r);
        alu_req.b  = 64'(mc_r);
        if (fin) begin
          ax_nxt    = 2'd0;
          state_nxt = (sq_r > alu_rsp.lo) ? cdf_pkg::S_SQRT : cdf_pkg::S_A;
        end
      end
      cdf_pkg::S_SQRT: begin
        alu_req.op = cdf_pkg::ALU_SQRT;
        alu_req.a  = sq_r;
        if (fin) begin
          len_nxt   = alu_rsp.lo[31:0];
          state_nxt = cdf_pkg::S_SCM;
        end
      end
      cdf_pkg::S_SCM: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(cdf_pkg::abs32(chg_r[ax_r]));
        alu_req.b  = 64'(mc_r);
        if (!wait_r) begin
          sign_nxt = chg_r[ax_r][31];
        end
        if (fin) begin
          pp_nxt    = alu_rsp.lo;
          state_nxt = cdf_pkg::S_SCD;
        end
      end
      cdf_pkg::S_SCD: begin
        alu_req.op = cdf_pkg::ALU_DIV;
        alu_req.a  = pp_r;
        alu_req.b  = 64'(len_r);
        if (fin) begin
          chg_nxt[ax_r] = cdf_pkg::sat32(q_s);
          if (ax_r == 2'd2) begin
            ax_nxt    = 2'd0;
            state_nxt = cdf_pkg::S_A;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = cdf_pkg::S_SCM;
          end
        end
      end
      cdf_pkg::S_A: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(om_r);
        alu_req.b  = 64'(cdf_pkg::abs32(chg_r[ax_r]));
        if (!wait_r) begin
          sign_nxt = chg_r[ax_r][31];
        end
        if (fin) begin
          s_nxt     = cdf_pkg::sat32(64'(vel_r[ax_r]) + m_s);
          state_nxt = cdf_pkg::S_B;
        end
      end
      cdf_pkg::S_B: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(cdf_pkg::abs32(s_r));
        alu_req.b  = 64'(dt_r);
        if (!wait_r) begin
          sign_nxt = s_r[31];
        end
        if (fin) begin
          tmp_nxt   = cdf_pkg::sat32(m_s);
          state_nxt = cdf_pkg::S_C;
        end
      end
      cdf_pkg::S_C: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(om_r);
        alu_req.b  = 64'(cdf_pkg::abs32(tmp_r));
        if (!wait_r) begin
          sign_nxt = tmp_r[31];
        end
        if (fin) begin
          s_nxt     = cdf_pkg::sat32(64'(vel_r[ax_r]) - m_s);
          state_nxt = cdf_pkg::S_D;
        end
      end
      cdf_pkg::S_D: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(cdf_pkg::abs32(s_r));
        alu_req.b  = 64'(dec_r);
        if (!wait_r) begin
          sign_nxt = s_r[31];
        end
        if (fin) begin
          nv_nxt[ax_r] = cdf_pkg::sat32(m_s);
          state_nxt    = cdf_pkg::S_E;
        end
      end
      cdf_pkg::S_E: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(cdf_pkg::abs32(w));
        alu_req.b  = 64'(dec_r);
        if (!wait_r) begin
          sign_nxt = w[31];
        end
        if (fin) begin
          o_nxt[ax_r] = cdf_pkg::sat32(64'(cur_r[ax_r]) - 64'(chg_r[ax_r]) + m_s);
          if (ax_r == 2'd2) begin
            ax_nxt    = 2'd0;
            dot_nxt   = '0;
            state_nxt = cdf_pkg::S_DOT;
          end else begin
            ax_nxt    = ax_r + 2'd1;
            state_nxt = cdf_pkg::S_A;
          end
        end
      end
      cdf_pkg::S_DOT: begin
        alu_req.op = cdf_pkg::ALU_MUL;
        alu_req.a  = 64'(cdf_pkg::abs32(va));
        alu_req.b  = 64'(cdf_pkg::abs32(vb));
        if (!wait_r) begin
          sign_nxt = va[31] ^ vb[31];
        end
        if (fin) begin
          dot_nxt = sign_r ? dot_r - pd : dot_r + pd;
          if (ax_r == 2'd2) begin
            state_nxt = cdf_pkg::S_DONE;
          end else begin
            ax_nxt = ax_r + 2'd1;
          end
        end
      end
      cdf_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          for (int i = 0; i < 3; i++) begin
            vel_nxt[i] = over ? 32'sd0 : nv_r[i];
            out_data_nxt[32*i +: 32]      = over ? tgt_r[i] : o_r[i];
            out_data_nxt[96 + 32*i +: 32] = over ? 32'sd0 : nv_r[i];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = cdf_pkg::S_IDLE;
        end
      end
      default: state_nxt = cdf_pkg::S_IDLE;
    endcase

    if (state_r != cdf_pkg::S_IDLE && state_r != cdf_pkg::S_DONE) begin
      alu_req.start = !wait_r;
      wait_nxt      = wait_r ? !alu_rsp.done : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cdf_pkg::S_IDLE;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= 31'(ONE_Q);
      ms_r        <= 31'h7FFF_FFFF;
      ax_r        <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        vel_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
      st_r        <= st_nxt;
      ms_r        <= ms_nxt;
      ax_r        <= ax_nxt;
      vel_r       <= vel_nxt;
    end
    dt_r   <= dt_nxt;   om_r  <= om_nxt;  mc_r  <= mc_nxt;  x_r   <= x_nxt;
    x2_r   <= x2_nxt;   x3_r  <= x3_nxt;  t1_r  <= t1_nxt;  den_r <= den_nxt;
    sq_r   <= sq_nxt;   pp_r  <= pp_nxt;  dec_r <= dec_nxt; len_r <= len_nxt;
    s_r    <= s_nxt;    tmp_r <= tmp_nxt; dot_r <= dot_nxt; sign_r <= sign_nxt;
    cur_r  <= cur_nxt;  tgt_r <= tgt_nxt; chg_r <= chg_nxt;
    nv_r   <= nv_nxt;   o_r   <= o_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == cdf_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !alu_rsp.busy) else $error("shared unit busy while idle");
  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    alu_rsp.done |-> wait_r) else $error("unexpected result from shared unit");
  a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cdf_pkg::S_DONE && (!out_valid_r || out_tready)) |=> out_valid_r)
    else $error("finished transaction not presented");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second item taken");

endmodule

// ===== hdl/cdf_alu.sv =====
// Shared iterative arithmetic unit: shift-add multiply, restoring divide and
// integer square root, all on one 66-bit adder. Depends on cdf_pkg.
module cdf_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  cdf_pkg::alu_req_t req,
  output cdf_pkg::alu_rsp_t rsp
);

  cdf_pkg::alu_op_t op_r, op_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic [63:0] bv_r, bv_nxt;
  logic [64:0] rs;
  logic [65:0] opa, opb, sum;
  logic        sub, borrow;

  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    lo_nxt   = lo_r;
    bv_nxt   = bv_r;
    rs       = {acc_r, lo_r[63]};
    opa      = 66'(acc_r);
    opb      = '0;
    sub      = 1'b0;
    case (op_r)
      cdf_pkg::ALU_MUL: begin
        opb = lo_r[0] ? 66'(bv_r) : '0;
      end
      cdf_pkg::ALU_DIV: begin
        opa = 66'(rs);
        opb = 66'(bv_r);
        sub = 1'b1;
      end
      cdf_pkg::ALU_SQRT: begin
        opb = 66'(lo_r | bv_r);
        sub = 1'b1;
      end
      default: ;
    endcase
    sum    = opa + (sub ? ~opb : opb) + 66'(sub);
    borrow = sum[65];
    if (busy_r) begin
      case (op_r)
        cdf_pkg::ALU_MUL: begin
          acc_nxt = sum[64:1];
          lo_nxt  = {sum[0], lo_r[63:1]};
        end
        cdf_pkg::ALU_DIV: begin
          acc_nxt = borrow ? rs[63:0] : sum[63:0];
          lo_nxt  = {lo_r[62:0], !borrow};
        end
        cdf_pkg::ALU_SQRT: begin
          if (!borrow) begin
            acc_nxt = sum[63:0];
            lo_nxt  = (lo_r >> 1) | bv_r;
          end else begin
            lo_nxt = lo_r >> 1;
          end
          bv_nxt = bv_r >> 2;
        end
        default: ;
      endcase
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (req.start) begin
      op_nxt   = req.op;
      busy_nxt = 1'b1;
      case (req.op)
        cdf_pkg::ALU_SQRT: begin
          acc_nxt = req.a;
          lo_nxt  = '0;
          bv_nxt  = 64'h4000_0000_0000_0000;
          cnt_nxt = 7'd32;
        end
        default: begin
          acc_nxt = '0;
          lo_nxt  = req.a;
          bv_nxt  = req.b;
          cnt_nxt = 7'd64;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= cdf_pkg::ALU_MUL;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
      op_r   <= op_nxt;
    end
    acc_r <= acc_nxt;
    lo_r  <= lo_nxt;
    bv_r  <= bv_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.lo   = lo_r;
  assign rsp.hi   = acc_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("result flagged while still iterating");
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != 7'd0) else $error("iteration count empty while busy");
  a_start_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy_r && req.start) |=> busy_r) else $error("start not taken");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for critically_damped_follower: directed table, then random
// phases under several register settings and handshake idling patterns, checked
// against an in-bench fixed-point predictor. Depends on the RTL only.
`timescale 1ns / 1ps

module testbench;

  localparam longint S32MAX  = 64'sd2147483647;
  localparam longint S32MIN  = -64'sd2147483648;
  localparam longint DEN_CAP = (64'sd1 << 32) + 1;
  localparam longint K048    = (48 * 65536 + 50) / 100;
  localparam longint K0235   = (235 * 65536 + 500) / 1000;
  localparam longint ST_MIN  = (65536 + 5000) / 10000;
  localparam int     LIMIT   = 12000000;
  localparam logic   REG_SMOOTH = 1'b0;
  localparam logic   REG_SPEED  = 1'b1;

  typedef struct {
    int          cur[3];
    int          tgt[3];
    int unsigned dt;
  } step_in_t;

  typedef struct {
    int pos[3];
    int vel[3];
  } step_out_t;

  typedef struct {
    step_in_t  stim;
    bit        typed;
    step_out_t want;
  } table_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [223:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [191:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = REG_SMOOTH;
  logic [30:0]  cfg_wdata = '0;

  critically_damped_follower dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  longint    smooth_reg;
  longint    speed_reg;
  longint    vel_state[3];
  step_out_t pending[$];
  int        mismatches = 0;
  int        gap_pct = 0;
  int        stall_pct = 0;
  bit        hold_go = 1'b0;
  bit        hold_used = 1'b0;
  int        hold_cnt = 0;
  int        cycles = 0;

  function automatic longint clamp32(longint v);
    return v > S32MAX ? S32MAX : (v < S32MIN ? S32MIN : v);
  endfunction

  function automatic longint clampsym(longint v);
    return v > S32MAX ? S32MAX : (v < -S32MAX ? -S32MAX : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) return p >>> 16;
    return -((-p) >>> 16);
  endfunction

  function automatic longint unsigned capped_mul(longint unsigned a, longint unsigned b);
    longint unsigned r;
    if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a) return DEN_CAP;
    r = (a * b) >> 16;
    return r > DEN_CAP ? DEN_CAP : r;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Advances the velocity state by one step and returns the smoothed position and new velocity.
  function automatic step_out_t follow_step(step_in_t s);
    longint unsigned x, x2, x3, den, sq, mc2;
    longint st, dt, om, dec, mc, len, tmp, s01;
    longint c[3], t[3], off[3], nv[3], o[3], a[3], b[3];
    step_out_t r;
    st = smooth_reg < ST_MIN ? ST_MIN : smooth_reg;
    dt = s.dt;
    om = (64'sd2 << 32) / st;
    if (om > S32MAX) om = S32MAX;
    x = longint'(om * dt) >> 16;
    x2 = capped_mul(x, x);
    x3 = capped_mul(x2, x);
    den = 65536 + (x > DEN_CAP ? DEN_CAP : x) + capped_mul(K048, x2) + capped_mul(K0235, x3);
    if (den > DEN_CAP) den = DEN_CAP;
    dec = longint'((64'd1 << 32) / den);
    mc = (speed_reg * st) >>> 16;
    if (mc > S32MAX) mc = S32MAX;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      c[i] = s.cur[i];
      t[i] = s.tgt[i];
      off[i] = clamp32(c[i] - t[i]);
      sq += longint'(off[i] * off[i]);
    end
    mc2 = mc * mc;
    if (sq > mc2) begin
      len = longint'(root64(sq));
      for (int i = 0; i < 3; i++) off[i] = clamp32(off[i] * mc / len);
    end
    for (int i = 0; i < 3; i++) begin
      tmp = clamp32(qmul(clamp32(vel_state[i] + qmul(om, off[i])), dt));
      nv[i] = clamp32(qmul(clamp32(vel_state[i] - qmul(om, tmp)), dec));
      o[i] = clamp32(c[i] - off[i] + qmul(clamp32(off[i] + tmp), dec));
      a[i] = clampsym(t[i] - c[i]);
      b[i] = clampsym(o[i] - t[i]);
    end
    s01 = a[0] * b[0] + a[1] * b[1];
    if (s01 > -(a[2] * b[2])) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = t[i];
        nv[i] = 0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      vel_state[i] = nv[i];
      r.pos[i] = int'(o[i]);
      r.vel[i] = int'(nv[i]);
    end
    return r;
  endfunction

  function automatic step_in_t make_step(int a0, int a1, int a2, int b0, int b1, int b2,
                                         int unsigned dt);
    step_in_t s;
    s.cur = '{a0, a1, a2};
    s.tgt = '{b0, b1, b2};
    s.dt = dt;
    return s;
  endfunction

  function automatic int near_value(int centre);
    longint v;
    v = longint'(centre) + $signed($urandom_range(0, 1 << 20)) - (1 << 19);
    return int'(clamp32(v));
  endfunction

  function automatic step_in_t random_step();
    step_in_t s;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      if (kind < 2) begin
        s.cur[i] = $urandom;
        s.tgt[i] = $urandom;
      end else begin
        s.tgt[i] = near_value(int'($urandom_range(0, 1 << 24)) - (1 << 23));
        s.cur[i] = near_value(s.tgt[i]);
      end
    end
    case ($urandom_range(0, 4))
      0: s.dt = $urandom & 32'h7FFF_FFFF;
      1: s.dt = $urandom_range(0, 255);
      default: s.dt = $urandom_range(1, 1 << 17);
    endcase
    return s;
  endfunction

  task automatic write_reg(logic idx, longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[30:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SMOOTH) smooth_reg = val & 64'h7FFF_FFFF;
    else speed_reg = val & 64'h7FFF_FFFF;
  endtask

  task automatic drain();
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_step(step_in_t s, bit typed, step_out_t want);
    step_out_t got;
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, s.dt[30:0], s.tgt[2], s.tgt[1], s.tgt[0], s.cur[2], s.cur[1], s.cur[0]};
    do @(posedge clk); while (!in_tready);
    got = follow_step(s);
    pending.push_back(typed ? want : got);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic run_phase(int n, int gap, int stall);
    step_out_t none;
    gap_pct = gap;
    stall_pct = stall;
    for (int k = 0; k < n; k++) send_step(random_step(), 1'b0, none);
    in_tvalid <= 1'b0;
    drain();
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_tready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_go && !hold_used) begin
      out_tready <= 1'b0;
      hold_cnt <= 8000;
      hold_used <= 1'b1;
    end else begin
      out_tready <= $urandom_range(0, 99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    step_out_t w;
    int f;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", out_tdata);
      end else begin
        w = pending.pop_front();
        for (f = 0; f < 6; f++) begin
          if (out_tdata[32*f +: 32] != (f < 3 ? w.pos[f] : w.vel[f - 3])) begin
            mismatches++;
            if (mismatches <= 10)
              $display("field %0d: expected %h, got %h", f,
                       f < 3 ? w.pos[f] : w.vel[f - 3], out_tdata[32*f +: 32]);
          end
        end
      end
    end
  end

  table_row_t rows[$];
  step_out_t  zero_out;
  step_out_t  five_out;

  initial begin
    smooth_reg = 65536;
    speed_reg = S32MAX;
    vel_state = '{0, 0, 0};
    zero_out.pos = '{0, 0, 0};
    zero_out.vel = '{0, 0, 0};
    five_out.pos = '{327680, -327680, 0};
    five_out.vel = '{0, 0, 0};
    rows.push_back('{make_step(0, 0, 0, 0, 0, 0, 65536), 1'b1, zero_out});
    rows.push_back('{make_step(327680, -327680, 0, 327680, -327680, 0, 6553), 1'b1, five_out});
    rows.push_back('{make_step(655360, 0, 0, 0, 0, 0, 1092), 1'b0, zero_out});
    rows.push_back('{make_step(600000, 0, 0, 0, 0, 0, 1092), 1'b0, zero_out});
    rows.push_back('{make_step(0, 655360, -65536, 0, 0, 0, 0), 1'b0, zero_out});
    rows.push_back('{make_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1), 1'b0, zero_out});
    rows.push_back('{make_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                     1'b0, zero_out});
    rows.push_back('{make_step(6553600, -65536, 0, 0, 0, 0, 32'h7FFF_FFFF), 1'b0, zero_out});
    rows.push_back('{make_step(-1, 1, -1, 1, -1, 1, 65536), 1'b0, zero_out});
    rows.push_back('{make_step(100000, 200000, 300000, -100000, 0, 100000, 3000), 1'b0,
                     zero_out});
    rows.push_back('{make_step(32'hFFFF_0000, 0, 32'h0000_FFFF, 0, 32'hFFFF_0000, 0, 100000),
                     1'b0, zero_out});
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[r]) send_step(rows[r].stim, rows[r].typed, rows[r].want);
    in_tvalid <= 1'b0;
    drain();

    write_reg(REG_SMOOTH, 0);
    write_reg(REG_SPEED, 0);
    foreach (rows[r]) if (r >= 2) send_step(rows[r].stim, 1'b0, zero_out);
    in_tvalid <= 1'b0;
    drain();

    write_reg(REG_SMOOTH, 65536);
    write_reg(REG_SPEED, 65536 * 4);
    run_phase(120, 0, 0);
    write_reg(REG_SMOOTH, S32MAX);
    write_reg(REG_SPEED, S32MAX);
    run_phase(120, 57, 0);
    write_reg(REG_SMOOTH, 3);
    write_reg(REG_SPEED, 65536);
    run_phase(120, 0, 57);
    write_reg(REG_SMOOTH, $urandom & 32'h7FFF_FFFF);
    write_reg(REG_SPEED, $urandom & 32'h7FFF_FFFF);
    hold_go = 1'b1;
    run_phase(120, 0, 0);
    write_reg(REG_SMOOTH, $urandom_range(7, 1 << 18));
    write_reg(REG_SPEED, $urandom_range(0, 1 << 22));
    run_phase(120, 12, 12);
    write_reg(REG_SMOOTH, 32768);
    write_reg(REG_SPEED, S32MAX);
    run_phase(130, 0, 0);

    repeat (3000) @(posedge clk);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
